// ===== sv/bcd_pkg.sv =====
// shared types and constants for the button click detector
package bcd_pkg;

  localparam int unsigned DEB_W  = 4;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [DEB_W-1:0]  DEB_COUNT_RST  = 4'd3;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST = 10'd100;
  localparam logic [TICK_W-1:0] DC_WINDOW_RST  = 10'd30;
  localparam logic [1:0]        DOUBLE_PRESSES = 2'd2;

  typedef enum logic [1:0] {
    REG_DEB_COUNT  = 2'd0,
    REG_LONG_TICKS = 2'd1,
    REG_DC_WINDOW  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_LONG    = 2'd2
  } phase_t;

  typedef struct packed {
    logic action;
    logic pin_level;
  } item_t;

  typedef struct packed {
    logic [DEB_W-1:0]  deb_count;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] dc_window;
  } cfg_t;

endpackage

// ===== sv/bcd_debounce.sv =====
// debounce counter and stable pin level
module bcd_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick,
  input  logic                       pin_level,
  input  logic [bcd_pkg::DEB_W-1:0]  deb_count,
  output logic                       stable_nxt
);

  logic                      stable_r;
  logic [bcd_pkg::DEB_W-1:0] cnt_r, cnt_nxt, cnt_inc;

  always_comb begin
    cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    cnt_nxt    = cnt_r;
    stable_nxt = stable_r;
    if (tick) begin
      if (pin_level != stable_r) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= deb_count) begin
          stable_nxt = pin_level;
          cnt_nxt    = '0;
        end
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b1;
      cnt_r    <= '0;
    end else begin
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/bcd_press_fsm.sv =====
// press timing state machine and event latch
module bcd_press_fsm #(
  parameter int unsigned COUNTER_BITS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  bcd_pkg::item_t item,
  input  logic           stable,
  input  bcd_pkg::cfg_t  cfg,
  output logic [1:0]     event_res
);

  localparam int unsigned CMP_W = (COUNTER_BITS > bcd_pkg::TICK_W) ?
                                  COUNTER_BITS : bcd_pkg::TICK_W;

  bcd_pkg::phase_t          phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0]  press_r, press_nxt, press_inc;
  logic [COUNTER_BITS-1:0]  rel_r, rel_nxt, rel_inc;
  logic [1:0]               spc_r, spc_nxt, spc_inc;
  logic [1:0]               latch_r, latch_nxt;
  logic [CMP_W-1:0]         press_ext, press_inc_ext, rel_inc_ext, long_ext, win_ext;
  logic                     tick, rd;

  assign tick          = en && (item.action == bcd_pkg::ACT_TICK);
  assign rd            = en && (item.action == bcd_pkg::ACT_READ);
  assign press_inc     = (press_r == '1) ? press_r : press_r + 1'b1;
  assign rel_inc       = (rel_r == '1) ? rel_r : rel_r + 1'b1;
  assign spc_inc       = spc_r + 2'd1;
  assign press_ext     = CMP_W'(press_r);
  assign press_inc_ext = CMP_W'(press_inc);
  assign rel_inc_ext   = CMP_W'(rel_inc);
  assign long_ext      = CMP_W'(cfg.long_ticks);
  assign win_ext       = CMP_W'(cfg.dc_window);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      case (phase_r)
        bcd_pkg::PH_IDLE:    if (!stable) phase_nxt = bcd_pkg::PH_PRESSED;
        bcd_pkg::PH_PRESSED: begin
          if (stable) phase_nxt = bcd_pkg::PH_IDLE;
          else if (press_inc_ext >= long_ext) phase_nxt = bcd_pkg::PH_LONG;
        end
        bcd_pkg::PH_LONG:    if (stable) phase_nxt = bcd_pkg::PH_IDLE;
        default:             phase_nxt = bcd_pkg::PH_IDLE;
      endcase
    end
  end

  // counters and event latch
  always_comb begin
    press_nxt = press_r;
    rel_nxt   = rel_r;
    spc_nxt   = spc_r;
    latch_nxt = latch_r;
    event_res = bcd_pkg::EV_NONE;
    if (rd) begin
      event_res = latch_r;
      latch_nxt = bcd_pkg::EV_NONE;
    end else if (tick) begin
      case (phase_r)
        bcd_pkg::PH_IDLE: begin
          if (!stable) press_nxt = '0;
          // pending single click times out even on the tick a press lands
          if (spc_r != 2'd0) begin
            if (rel_inc_ext >= win_ext) begin
              latch_nxt = bcd_pkg::EV_SINGLE;
              spc_nxt   = '0;
              rel_nxt   = '0;
            end else begin
              rel_nxt = rel_inc;
            end
          end
        end
        bcd_pkg::PH_PRESSED: begin
          if (!stable) begin
            press_nxt = press_inc;
          end else begin
            if (press_ext < long_ext) begin
              if (spc_inc >= bcd_pkg::DOUBLE_PRESSES) begin
                latch_nxt = bcd_pkg::EV_DOUBLE;
                spc_nxt   = '0;
              end else begin
                spc_nxt = spc_inc;
              end
              rel_nxt = '0;
            end
            press_nxt = '0;
          end
        end
        bcd_pkg::PH_LONG: begin
          if (stable) begin
            latch_nxt = bcd_pkg::EV_LONG;
            press_nxt = '0;
            spc_nxt   = '0;
            rel_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcd_pkg::PH_IDLE;
      press_r <= '0;
      rel_r   <= '0;
      spc_r   <= '0;
      latch_r <= bcd_pkg::EV_NONE;
    end else begin
      phase_r <= phase_nxt;
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      spc_r   <= spc_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

// ===== sv/button_click_detector.sv =====
// top level: request register, config registers, debounce, press fsm, result register
// an accepted request goes via the request register and result register to out_valid
// throughput: one request per cycle; the result register lets the next request in
// while a result waits, and in_stall rises only when both stages are full
// reset (synchronous, rst_n low): pin released, all counters and the event latch
// cleared, registers back to debounce 3, long press 100, double click window 30
module button_click_detector #(
  parameter int unsigned COUNTER_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic                        in_pin_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_event_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcd_pkg::DATA_W-1:0]  pwdata,
  output logic [bcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  bcd_pkg::cfg_t   cfg_r;
  bcd_pkg::item_t  item_r;
  logic            item_vld_r;
  logic            out_vld_r;
  logic [1:0]      out_ev_r;
  logic            advance;
  logic            stable_nxt;
  logic [1:0]      ev_res;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // request moves into the result register when that register is free or draining
  assign advance   = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = item_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_event_res = out_ev_r;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      bcd_pkg::REG_DEB_COUNT:  prdata = bcd_pkg::DATA_W'(cfg_r.deb_count);
      bcd_pkg::REG_LONG_TICKS: prdata = bcd_pkg::DATA_W'(cfg_r.long_ticks);
      bcd_pkg::REG_DC_WINDOW:  prdata = bcd_pkg::DATA_W'(cfg_r.dc_window);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deb_count  <= bcd_pkg::DEB_COUNT_RST;
      cfg_r.long_ticks <= bcd_pkg::LONG_TICKS_RST;
      cfg_r.dc_window  <= bcd_pkg::DC_WINDOW_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        bcd_pkg::REG_DEB_COUNT:  cfg_r.deb_count  <= pwdata[bcd_pkg::DEB_W-1:0];
        bcd_pkg::REG_LONG_TICKS: cfg_r.long_ticks <= pwdata[bcd_pkg::TICK_W-1:0];
        bcd_pkg::REG_DC_WINDOW:  cfg_r.dc_window  <= pwdata[bcd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) item_vld_r <= 1'b1;
      else if (advance)          item_vld_r <= 1'b0;
      if (advance)               out_vld_r  <= 1'b1;
      else if (!out_stall)       out_vld_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.action    <= in_action;
      item_r.pin_level <= in_pin_level;
    end
    if (advance) out_ev_r <= ev_res;
  end

  bcd_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (advance && (item_r.action == bcd_pkg::ACT_TICK)),
    .pin_level  (item_r.pin_level),
    .deb_count  (cfg_r.deb_count),
    .stable_nxt (stable_nxt)
  );

  bcd_press_fsm #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_press_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .item      (item_r),
    .stable    (stable_nxt),
    .cfg       (cfg_r),
    .event_res (ev_res)
  );

endmodule

// ===== dv/button_click_detector_tb.sv =====
// testbench for the button click detector: random press gestures checked against a predictor
module button_click_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNTER_BITS = 10;
  localparam int unsigned TICK_MAX     = (1 << COUNTER_BITS) - 1;
  localparam int unsigned DEB_MAX      = (1 << bcd_pkg::DEB_W) - 1;
  localparam int unsigned BAD_REG      = 3;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned CALM_LO      = 2000;
  localparam int unsigned CALM_HI      = 4500;
  localparam int unsigned SETTLE       = 4;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       in_action    = 1'b0;
  logic                       in_pin_level = 1'b1;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [1:0]                 out_event_res;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [bcd_pkg::ADDR_W-1:0] paddr        = '0;
  logic [bcd_pkg::DATA_W-1:0] pwdata       = '0;
  logic [bcd_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  button_click_detector #(.COUNTER_BITS(COUNTER_BITS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_pin_level (in_pin_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // register copies
  logic [bcd_pkg::DEB_W-1:0]  cfg_deb;
  logic [bcd_pkg::TICK_W-1:0] cfg_long;
  logic [bcd_pkg::TICK_W-1:0] cfg_win;

  // detector state
  logic                       stb_lvl;
  logic [bcd_pkg::DEB_W-1:0]  deb_cnt;
  bcd_pkg::phase_t            ph;
  logic [bcd_pkg::TICK_W-1:0] hold_ticks;
  logic [bcd_pkg::TICK_W-1:0] gap_ticks;
  logic [1:0]                 clicks;
  bcd_pkg::event_t            latch;

  bcd_pkg::item_t  stim_q[$];
  bcd_pkg::item_t  cur;
  bcd_pkg::event_t due_events[$];
  bcd_pkg::event_t want_ev;
  int unsigned     errors = 0;
  int unsigned     cyc    = 0;
  int unsigned     quiet  = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [bcd_pkg::TICK_W-1:0] tick_inc(logic [bcd_pkg::TICK_W-1:0] v);
    return (v >= TICK_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bcd_pkg::event_t click_step(logic act, logic pin);
    bcd_pkg::event_t res;
    res = bcd_pkg::EV_NONE;
    if (act == bcd_pkg::ACT_READ) begin
      res   = latch;
      latch = bcd_pkg::EV_NONE;
    end else begin
      if (pin != stb_lvl) begin
        if (deb_cnt < DEB_MAX) deb_cnt = deb_cnt + 1'b1;
        if (deb_cnt >= cfg_deb) begin
          stb_lvl = pin;
          deb_cnt = '0;
        end
      end else begin
        deb_cnt = '0;
      end
      case (ph)
        bcd_pkg::PH_IDLE: begin
          if (!stb_lvl) begin
            ph         = bcd_pkg::PH_PRESSED;
            hold_ticks = '0;
          end
          // pending click times out even on the tick a press is taken
          if (clicks != 0) begin
            gap_ticks = tick_inc(gap_ticks);
            if (gap_ticks >= cfg_win) begin
              latch     = bcd_pkg::EV_SINGLE;
              clicks    = '0;
              gap_ticks = '0;
            end
          end
        end
        bcd_pkg::PH_PRESSED: begin
          if (!stb_lvl) begin
            hold_ticks = tick_inc(hold_ticks);
            if (hold_ticks >= cfg_long) ph = bcd_pkg::PH_LONG;
          end else begin
            if (hold_ticks < cfg_long) begin
              clicks = clicks + 1'b1;
              if (clicks >= bcd_pkg::DOUBLE_PRESSES) begin
                latch  = bcd_pkg::EV_DOUBLE;
                clicks = '0;
              end
              gap_ticks = '0;
            end
            ph         = bcd_pkg::PH_IDLE;
            hold_ticks = '0;
          end
        end
        bcd_pkg::PH_LONG: begin
          if (stb_lvl) begin
            latch      = bcd_pkg::EV_LONG;
            ph         = bcd_pkg::PH_IDLE;
            hold_ticks = '0;
            clicks     = '0;
            gap_ticks  = '0;
          end
        end
        default: ph = bcd_pkg::PH_IDLE;
      endcase
    end
    return res;
  endfunction

  function automatic bit idle_now();
    return (cyc < CALM_LO || cyc >= CALM_HI) && ($urandom_range(0, 99) < 38);
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_events.push_back(click_step(cur.action, cur.pin_level));
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && !idle_now()) begin
          cur = stim_q.pop_front();
          in_valid     <= 1'b1;
          in_action    <= cur.action;
          in_pin_level <= cur.pin_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_events.size() == 0) begin
        report("result with nothing outstanding", out_event_res, 0);
      end else begin
        want_ev = due_events.pop_front();
        if (out_event_res !== want_ev) report("event_res", out_event_res, want_ev);
      end
    end
    out_stall <= idle_now();
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("button_click_detector_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic apb_write(input int unsigned addr, input logic [bcd_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bcd_pkg::ADDR_W'(addr);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input int unsigned addr, output logic [bcd_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= bcd_pkg::ADDR_W'(addr);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write one register with junk above its width, then read it back
  task automatic write_reg(input bcd_pkg::reg_idx_t idx, input int unsigned val,
                           input int unsigned w);
    logic [bcd_pkg::DATA_W-1:0] mask;
    logic [bcd_pkg::DATA_W-1:0] rd;
    mask = (32'd1 << w) - 1;
    apb_write(idx * 4, ($urandom() & ~mask) | (val & mask));
    case (idx)
      bcd_pkg::REG_DEB_COUNT:  cfg_deb  = bcd_pkg::DEB_W'(val);
      bcd_pkg::REG_LONG_TICKS: cfg_long = bcd_pkg::TICK_W'(val);
      default:                 cfg_win  = bcd_pkg::TICK_W'(val);
    endcase
    apb_read(idx * 4, rd);
    if (rd !== (val & mask)) report("register readback", rd, val & mask);
  endtask

  task automatic set_regs(input int unsigned deb, input int unsigned lng, input int unsigned win);
    write_reg(bcd_pkg::REG_DEB_COUNT, deb, bcd_pkg::DEB_W);
    write_reg(bcd_pkg::REG_LONG_TICKS, lng, bcd_pkg::TICK_W);
    write_reg(bcd_pkg::REG_DC_WINDOW, win, bcd_pkg::TICK_W);
  endtask

  task automatic put(input logic act, input logic pin);
    bcd_pkg::item_t it;
    it.action    = act;
    it.pin_level = pin;
    stim_q.push_back(it);
  endtask

  task automatic ticks(input logic pin, input int unsigned n);
    repeat (n) put(bcd_pkg::ACT_TICK, pin);
  endtask

  // held level with the odd contact bounce and stray reads
  task automatic hold(input logic pin, input int unsigned n);
    repeat (n) begin
      put(bcd_pkg::ACT_TICK, ($urandom_range(0, 99) < 4) ? !pin : pin);
      if ($urandom_range(0, 99) < 6) put(bcd_pkg::ACT_READ, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic gesture();
    int unsigned d;
    int unsigned l;
    int unsigned w;
    d = (cfg_deb == 0) ? 1 : cfg_deb;
    l = (cfg_long == 0) ? 1 : cfg_long;
    w = (cfg_win == 0) ? 1 : cfg_win;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        hold(1'b0, d + $urandom_range(0, l));
        hold(1'b1, d + $urandom_range(0, w + 2));
      end
      3, 4: begin
        hold(1'b0, d + $urandom_range(0, l - 1));
        hold(1'b1, d + $urandom_range(0, w - 1));
        hold(1'b0, d + $urandom_range(0, l - 1));
        hold(1'b1, d + w + 2);
      end
      5, 6: begin
        hold(1'b0, d + l + $urandom_range(0, 4));
        hold(1'b1, d + $urandom_range(0, 6));
      end
      7: repeat ($urandom_range(3, 20)) put(bcd_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
      8: repeat ($urandom_range(1, 3)) put(bcd_pkg::ACT_READ, 1'($urandom_range(0, 1)));
      default: begin
        hold(1'b0, d + $urandom_range(0, 2));
        hold(1'b1, d + $urandom_range(w, w + 4));
      end
    endcase
    if ($urandom_range(0, 99) < 60) put(bcd_pkg::ACT_READ, 1'($urandom_range(0, 1)));
  endtask

  task automatic fill(input int unsigned n);
    while (stim_q.size() < n) gesture();
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_valid || due_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    cfg_deb    = bcd_pkg::DEB_COUNT_RST;
    cfg_long   = bcd_pkg::LONG_TICKS_RST;
    cfg_win    = bcd_pkg::DC_WINDOW_RST;
    stb_lvl    = 1'b1;
    deb_cnt    = '0;
    ph         = bcd_pkg::PH_IDLE;
    hold_ticks = '0;
    gap_ticks  = '0;
    clicks     = '0;
    latch      = bcd_pkg::EV_NONE;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty latch, single, double, long, clear on read
    set_regs(1, 3, 2);
    put(bcd_pkg::ACT_READ, 1'b1);
    put(bcd_pkg::ACT_READ, 1'b0);
    ticks(1'b0, 1); ticks(1'b1, 3); put(bcd_pkg::ACT_READ, 1'b1);
    ticks(1'b0, 1); ticks(1'b1, 1); ticks(1'b0, 1); ticks(1'b1, 1);
    put(bcd_pkg::ACT_READ, 1'b0);
    ticks(1'b0, 5); ticks(1'b1, 1); put(bcd_pkg::ACT_READ, 1'b1);
    put(bcd_pkg::ACT_READ, 1'b0);
    drain();

    // zero debounce and window registers act as one; a write past the last register is dropped
    set_regs(0, 0, 0);
    apb_write(BAD_REG * 4, $urandom());
    fill(70);
    drain();

    set_regs(bcd_pkg::DEB_COUNT_RST, bcd_pkg::LONG_TICKS_RST, bcd_pkg::DC_WINDOW_RST);
    fill(160);
    drain();

    set_regs(1, 1, 1);
    fill(70);
    drain();

    set_regs(15, 20, 12);
    fill(120);
    drain();

    set_regs($urandom_range(1, 6), $urandom_range(2, 40), $urandom_range(2, 30));
    fill(140);
    drain();

    // widest settings: one click left to time out over the full window
    set_regs(15, 1023, 1023);
    hold(1'b0, 17);
    hold(1'b1, 15 + 1030);
    put(bcd_pkg::ACT_READ, 1'b1);
    put(bcd_pkg::ACT_READ, 1'b0);
    drain();

    if (errors == 0) begin
      $display("button_click_detector_tb: clean");
    end else begin
      $display("button_click_detector_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bcd_pkg.sv
sv/bcd_debounce.sv
sv/bcd_press_fsm.sv
sv/button_click_detector.sv
dv/button_click_detector_tb.sv
